// ===== rtl/uvs_pkg.sv =====
package uvs_pkg;

	localparam int MAX_RINGS        = 64;
	localparam int MAX_SLICES       = 64;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int QUEUE_DEPTH      = 2;

	localparam int RADIUS_W  = 16;
	localparam int COUNT_W   = 7;
	localparam int POS_W     = 17;
	localparam int IDX_W     = 13;
	localparam int PHASE_W   = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd1280;
	localparam logic [COUNT_W-1:0]  RING_RST   = 7'd20;
	localparam logic [COUNT_W-1:0]  SLICE_RST  = 7'd20;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RING_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 2'd2;

	localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'd16384;

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		K_TOP  = 2'd0,
		K_BOT  = 2'd1,
		K_RING = 2'd2,
		K_TRI  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [RADIUS_W-1:0] radius;
		logic [COUNT_W-1:0]  ring_count;
		logic [COUNT_W-1:0]  slice_count;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [PHASE_W-1:0] theta;
		logic [PHASE_W-1:0] phi;
		logic [IDX_W-1:0]   idx_a;
		logic [IDX_W-1:0]   idx_b;
		logic [IDX_W-1:0]   idx_c;
		logic               last;
	} desc_t;

	typedef struct packed {
		logic             item_kind;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [POS_W-1:0] pos_z;
		logic [IDX_W-1:0] index_a;
		logic [IDX_W-1:0] index_b;
		logic [IDX_W-1:0] index_c;
		logic             last;
	} result_t;

	// q1.15 sine of a 32-bit phase, taylor series
	function automatic logic signed [15:0] rom_value(input longint unsigned u);
		longint unsigned quad;
		longint unsigned r;
		longint unsigned y;
		longint unsigned y2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned v;
		quad = (u >> 30) & 64'd3;
		r    = u & (Q30_ONE - 64'd1);
		if ((quad & 64'd1) != 64'd0)
			r = Q30_ONE - r;
		y  = (r * HALF_PI_Q30) >> 30;
		y2 = (y * y) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - ((y2 * t) >> 30) / 64'd110;
		t  = Q30_ONE - ((y2 * t) >> 30) / 64'd72;
		t  = Q30_ONE - ((y2 * t) >> 30) / 64'd42;
		t  = Q30_ONE - ((y2 * t) >> 30) / 64'd20;
		t  = Q30_ONE - ((y2 * t) >> 30) / 64'd6;
		s  = (y * t) >> 30;
		v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767)
			v = 64'd32767;
		if ((quad & 64'd2) != 64'd0)
			return 16'(-v);
		return 16'(v);
	endfunction

endpackage

// ===== rtl/uvs_queue.sv =====
module uvs_queue import uvs_pkg::*; #(
	parameter type T     = logic,
	parameter int  Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	T                mem_q [Depth];
	logic [PtrW-1:0] wptr_q;
	logic [PtrW-1:0] rptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CntW'(Depth));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/uvs_front.sv =====
module uvs_front import uvs_pkg::*; #(
	parameter int MaxRings  = MAX_RINGS,
	parameter int MaxSlices = MAX_SLICES
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  push,
	input  logic  restart,
	output logic  full,
	output logic  desc_push,
	output desc_t desc,
	input  logic  desc_full
);

	localparam int RingW    = $clog2(MaxRings + 2);
	localparam int SliceW   = $clog2(MaxSlices + 1);
	localparam int MaxDiv   = (MaxRings + 1 > MaxSlices) ? MaxRings + 1 : MaxSlices;
	localparam int DivW     = $clog2(MaxDiv + 1);
	localparam int DivSteps = 17;
	localparam int StepCntW = $clog2(DivSteps);

	typedef enum logic [5:0] {
		ST_TOP  = 6'b000001,
		ST_RING = 6'b000010,
		ST_BOT  = 6'b000100,
		ST_TFAN = 6'b001000,
		ST_QUAD = 6'b010000,
		ST_BFAN = 6'b100000
	} stage_t;

	stage_t              stage_q, stage_cur, stage_n;
	logic [RingW-1:0]    ring_q, ring_n, cur_ring;
	logic [SliceW-1:0]   slice_q, slice_n, cur_slice;
	logic                pair_q, pair_n;
	logic [PHASE_W-1:0]  sstep_q, rstep_q;
	logic [RingW-1:0]    r_eff;
	logic [SliceW-1:0]   s_eff;
	logic [RingW:0]      r_plus1;
	logic [RingW:0]      ring_inc;
	logic [SliceW:0]     slice_inc;
	logic                accept;

	logic                busy_q;
	logic [StepCntW-1:0] cnt_q;
	logic [DivW-1:0]     srem_q, rrem_q, sdiv_q, rdiv_q, srem_n, rrem_n;
	logic [16:0]         squo_q, rquo_q, squo_n, rquo_n;
	logic [DivW:0]       strial, rtrial;

	logic [IDX_W-1:0]    s13, r13, c13, k13, p13, cb13, l13, pole13;

	assign accept = push && !full;
	assign full   = busy_q || desc_full;

	always_comb begin
		if (cfg.ring_count == '0)
			r_eff = RingW'(1);
		else if (int'(cfg.ring_count) > MaxRings)
			r_eff = RingW'(MaxRings);
		else
			r_eff = RingW'(cfg.ring_count);
		if (int'(cfg.slice_count) < 3)
			s_eff = SliceW'(3);
		else if (int'(cfg.slice_count) > MaxSlices)
			s_eff = SliceW'(MaxSlices);
		else
			s_eff = SliceW'(cfg.slice_count);
	end

	assign r_plus1   = {1'b0, r_eff} + 1'b1;
	assign stage_cur = restart ? ST_TOP : stage_q;
	assign cur_ring  = restart ? '0 : ring_q;
	assign cur_slice = restart ? '0 : slice_q;
	assign ring_inc  = {1'b0, cur_ring} + 1'b1;
	assign slice_inc = {1'b0, cur_slice} + 1'b1;

	assign s13    = IDX_W'(s_eff);
	assign r13    = IDX_W'(r_eff);
	assign c13    = IDX_W'(cur_slice);
	assign k13    = IDX_W'(cur_ring);
	assign p13    = IDX_W'(1) + IDX_W'((k13 - IDX_W'(1)) * s13);
	assign cb13   = IDX_W'(1) + IDX_W'(k13 * s13);
	assign l13    = IDX_W'(1) + IDX_W'((r13 - IDX_W'(1)) * s13);
	assign pole13 = IDX_W'(r13 * s13) + IDX_W'(1);

	always_comb begin
		stage_n = stage_cur;
		ring_n  = cur_ring;
		slice_n = cur_slice;
		pair_n  = restart ? 1'b0 : pair_q;
		desc    = '0;
		unique case (stage_cur)
			ST_RING: begin
				desc.kind  = K_RING;
				desc.theta = PHASE_W'(PHASE_W'(cur_ring) * rstep_q);
				desc.phi   = PHASE_W'((PHASE_W'(s_eff) - PHASE_W'(cur_slice)) * sstep_q);
				slice_n    = SliceW'(slice_inc);
				if (slice_inc >= {1'b0, s_eff}) begin
					slice_n = '0;
					ring_n  = RingW'(ring_inc);
					if (ring_inc > {1'b0, r_eff})
						stage_n = ST_BOT;
				end
			end
			ST_BOT: begin
				desc.kind = K_BOT;
				stage_n   = ST_TFAN;
				slice_n   = '0;
			end
			ST_TFAN: begin
				desc.kind = K_TRI;
				if (slice_inc < {1'b0, s_eff}) begin
					desc.idx_a = c13 + IDX_W'(2);
					desc.idx_b = c13 + IDX_W'(1);
				end else begin
					desc.idx_a = IDX_W'(1);
					desc.idx_b = s13;
				end
				slice_n = SliceW'(slice_inc);
				if (slice_inc >= {1'b0, s_eff}) begin
					slice_n = '0;
					ring_n  = RingW'(1);
					pair_n  = 1'b0;
					stage_n = (r_eff > RingW'(1)) ? ST_QUAD : ST_BFAN;
				end
			end
			ST_QUAD: begin
				desc.kind = K_TRI;
				if (slice_inc < {1'b0, s_eff}) begin
					if (!pair_n) begin
						desc.idx_a = p13 + c13;
						desc.idx_b = p13 + c13 + IDX_W'(1);
						desc.idx_c = cb13 + c13;
					end else begin
						desc.idx_a = cb13 + c13 + IDX_W'(1);
						desc.idx_b = cb13 + c13;
						desc.idx_c = p13 + c13 + IDX_W'(1);
					end
				end else begin
					if (!pair_n) begin
						desc.idx_a = p13;
						desc.idx_b = cb13 + s13 - IDX_W'(1);
						desc.idx_c = p13 + s13 - IDX_W'(1);
					end else begin
						desc.idx_a = p13 + s13;
						desc.idx_b = cb13 + s13 - IDX_W'(1);
						desc.idx_c = p13;
					end
				end
				if (!pair_n) begin
					pair_n = 1'b1;
				end else begin
					pair_n  = 1'b0;
					slice_n = SliceW'(slice_inc);
					if (slice_inc >= {1'b0, s_eff}) begin
						slice_n = '0;
						ring_n  = RingW'(ring_inc);
						if (ring_inc >= {1'b0, r_eff})
							stage_n = ST_BFAN;
					end
				end
			end
			ST_BFAN: begin
				desc.kind = K_TRI;
				if (slice_inc < {1'b0, s_eff}) begin
					desc.idx_a = l13 + c13;
					desc.idx_b = l13 + c13 + IDX_W'(1);
					desc.idx_c = pole13;
					slice_n    = SliceW'(slice_inc);
				end else begin
					desc.idx_a = l13;
					desc.idx_b = pole13;
					desc.idx_c = l13 + s13 - IDX_W'(1);
					desc.last  = 1'b1;
					stage_n    = ST_TOP;
					slice_n    = '0;
					ring_n     = '0;
					pair_n     = 1'b0;
				end
			end
			default: begin
				desc.kind = K_TOP;
				stage_n   = ST_RING;
				ring_n    = RingW'(1);
				slice_n   = '0;
				pair_n    = 1'b0;
			end
		endcase
	end

	assign desc_push = accept;

	// restoring division for the two angle steps, one quotient bit per cycle
	always_comb begin
		strial = {srem_q, squo_q[16]};
		rtrial = {rrem_q, rquo_q[16]};
		if (strial >= {1'b0, sdiv_q}) begin
			srem_n = DivW'(strial - {1'b0, sdiv_q});
			squo_n = {squo_q[15:0], 1'b1};
		end else begin
			srem_n = DivW'(strial);
			squo_n = {squo_q[15:0], 1'b0};
		end
		if (rtrial >= {1'b0, rdiv_q}) begin
			rrem_n = DivW'(rtrial - {1'b0, rdiv_q});
			rquo_n = {rquo_q[15:0], 1'b1};
		end else begin
			rrem_n = DivW'(rtrial);
			rquo_n = {rquo_q[15:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_TOP;
			ring_q  <= '0;
			slice_q <= '0;
			pair_q  <= 1'b0;
			sstep_q <= '0;
			rstep_q <= '0;
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			srem_q  <= '0;
			rrem_q  <= '0;
			sdiv_q  <= '0;
			rdiv_q  <= '0;
			squo_q  <= '0;
			rquo_q  <= '0;
		end else begin
			if (accept) begin
				stage_q <= stage_n;
				ring_q  <= ring_n;
				slice_q <= slice_n;
				pair_q  <= pair_n;
			end
			if (accept && restart) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				srem_q <= '0;
				rrem_q <= '0;
				sdiv_q <= DivW'(s_eff);
				rdiv_q <= DivW'(r_plus1);
				squo_q <= 17'd65536 + 17'(s_eff >> 1);
				rquo_q <= 17'd32768 + 17'(r_plus1 >> 1);
			end else if (busy_q) begin
				srem_q <= srem_n;
				rrem_q <= rrem_n;
				squo_q <= squo_n;
				rquo_q <= rquo_n;
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == StepCntW'(DivSteps - 1)) begin
					busy_q  <= 1'b0;
					sstep_q <= squo_n[15:0];
					rstep_q <= rquo_n[15:0];
				end
			end
		end
	end

	a_restart_top: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && restart) |-> (desc_push && desc.kind == K_TOP))
		else $error("restart did not issue the top pole");

	a_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && restart) |=> (busy_q && full))
		else $error("step division not started on restart");

endmodule

// ===== rtl/uvs_back.sv =====
module uvs_back import uvs_pkg::*; #(
	parameter int SineDepth = SINE_TABLE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [RADIUS_W-1:0] radius,
	input  desc_t               desc,
	input  logic                desc_empty,
	output logic                desc_pop,
	output logic                res_push,
	output result_t             res,
	input  logic                res_full
);

	localparam int AddrW = $clog2(SineDepth);

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_T1   = 6'b000010,
		B_T2   = 6'b000100,
		B_T3   = 6'b001000,
		B_T4   = 6'b010000,
		B_T5   = 6'b100000
	} bstate_t;

	bstate_t             state_q;
	logic signed [15:0]  sine_tab [SineDepth];
	logic [AddrW-1:0]    rom_addr;
	logic signed [15:0]  rom_q;
	logic signed [15:0]  sinth_q;
	logic [PHASE_W-1:0]  theta_q, phi_q;
	logic signed [32:0]  rs_q;
	logic signed [32:0]  ymul;
	logic signed [48:0]  prod_q;
	logic [POS_W-1:0]    px_q, py_q;
	logic signed [16:0]  rad_s;
	logic                simple_go;

	for (genvar k = 0; k < SineDepth; k++) begin : g_rom
		localparam longint unsigned U = (64'(k) << 32) / SineDepth;
		assign sine_tab[k] = rom_value(U);
	end

	function automatic logic [AddrW-1:0] ph_idx(input logic [PHASE_W-1:0] ph);
		logic [AddrW+16:0] p;
		p = ((AddrW+17)'(ph) * (AddrW+17)'(SineDepth) + (AddrW+17)'(32768)) >> 16;
		if (p == (AddrW+17)'(SineDepth))
			return '0;
		return AddrW'(p);
	endfunction

	function automatic logic [POS_W-1:0] rnd15(input logic signed [32:0] p);
		logic [32:0] m;
		m = p[32] ? 33'(-p) : 33'(p);
		m = (m + 33'(1 << 14)) >> 15;
		return p[32] ? POS_W'(-m) : POS_W'(m);
	endfunction

	function automatic logic [POS_W-1:0] rnd30(input logic signed [48:0] p);
		logic [48:0] m;
		m = p[48] ? 49'(-p) : 49'(p);
		m = (m + 49'(64'd1 << 29)) >> 30;
		return p[48] ? POS_W'(-m) : POS_W'(m);
	endfunction

	assign rad_s = $signed({1'b0, radius});
	assign ymul  = rad_s * rom_q;

	always_comb begin
		unique case (state_q)
			B_T1:    rom_addr = ph_idx(theta_q + QUARTER_TURN);
			B_T2:    rom_addr = ph_idx(phi_q + QUARTER_TURN);
			B_T3:    rom_addr = ph_idx(phi_q);
			B_IDLE:  rom_addr = ph_idx(desc.theta);
			default: rom_addr = ph_idx(phi_q);
		endcase
	end

	always_ff @(posedge clk) begin
		rom_q <= sine_tab[rom_addr];
	end

	assign simple_go = (state_q == B_IDLE) && !desc_empty && (desc.kind != K_RING) && !res_full;
	assign desc_pop  = simple_go || ((state_q == B_IDLE) && !desc_empty && desc.kind == K_RING);
	assign res_push  = simple_go || ((state_q == B_T5) && !res_full);

	always_comb begin
		res = '0;
		if (state_q == B_T5) begin
			res.pos_x = px_q;
			res.pos_y = py_q;
			res.pos_z = rnd30(prod_q);
		end else begin
			unique case (desc.kind)
				K_TOP:   res.pos_y = POS_W'(rad_s);
				K_BOT:   res.pos_y = POS_W'(-rad_s);
				K_TRI: begin
					res.item_kind = 1'b1;
					res.index_a   = desc.idx_a;
					res.index_b   = desc.idx_b;
					res.index_c   = desc.idx_c;
					res.last      = desc.last;
				end
				default: res = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				theta_q <= desc.theta;
				phi_q   <= desc.phi;
			end
			B_T1: sinth_q <= rom_q;
			B_T2: begin
				rs_q <= rad_s * sinth_q;
				py_q <= rnd15(ymul);
			end
			B_T3: prod_q <= rs_q * rom_q;
			B_T4: begin
				px_q   <= rnd30(prod_q);
				prod_q <= rs_q * rom_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE:  if (desc_pop && desc.kind == K_RING) state_q <= B_T1;
				B_T1:    state_q <= B_T2;
				B_T2:    state_q <= B_T3;
				B_T3:    state_q <= B_T4;
				B_T4:    state_q <= B_T5;
				B_T5:    if (!res_full) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_ring_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE && desc_pop && desc.kind == K_RING) |=> (state_q == B_T1 && !res_push))
		else $error("ring vertex did not enter the trig sequence");

	a_vertex_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_T5 && !res_full) |-> (res_push && !desc_pop) ##1 (state_q == B_IDLE))
		else $error("ring vertex not delivered");

endmodule

// ===== rtl/uv_sphere_mesh_generator_top.sv =====
// UV sphere mesh generator. Each pushed item with restart low yields the next mesh item,
// with restart high the sequence starts over at the top pole. Poles and triangles pass the
// back end straight from idle; a ring vertex steps through the states B_T1 to B_T5, which
// serialise the four reads of the single sine ROM port and the multiplies. After a restart
// the input side reports full while the slice and ring angle steps are divided out a bit per cycle.
// Two-entry queues sit between the sequencer and the trig unit and in front of the result
// port, so either side may stall without stopping the other.
module uv_sphere_mesh_generator_top import uvs_pkg::*; #(
	parameter int MaxRings  = MAX_RINGS,
	parameter int MaxSlices = MAX_SLICES,
	parameter int SineDepth = SINE_TABLE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	input  logic                 push,
	output logic                 full,
	input  logic                 restart,
	output logic                 empty,
	input  logic                 pop,
	output logic                 item_kind,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z,
	output logic [IDX_W-1:0]     index_a,
	output logic [IDX_W-1:0]     index_b,
	output logic [IDX_W-1:0]     index_c,
	output logic                 last
);

	cfg_t    cfg_q;
	desc_t   desc_in, desc_out;
	logic    desc_push, desc_pop, desc_full, desc_empty;
	result_t res_in, res_out;
	logic    res_push, res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius      <= RADIUS_RST;
			cfg_q.ring_count  <= RING_RST;
			cfg_q.slice_count <= SLICE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RADIUS:      cfg_q.radius      <= wr_data[RADIUS_W-1:0];
				REG_RING_COUNT:  cfg_q.ring_count  <= wr_data[COUNT_W-1:0];
				REG_SLICE_COUNT: cfg_q.slice_count <= wr_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	uvs_front #(
		.MaxRings (MaxRings),
		.MaxSlices(MaxSlices)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.restart  (restart),
		.full     (full),
		.desc_push(desc_push),
		.desc     (desc_in),
		.desc_full(desc_full)
	);

	uvs_queue #(
		.T    (desc_t),
		.Depth(QUEUE_DEPTH)
	) u_desc_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (desc_push),
		.wdata (desc_in),
		.full  (desc_full),
		.pop   (desc_pop),
		.rdata (desc_out),
		.empty (desc_empty)
	);

	uvs_back #(
		.SineDepth(SineDepth)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.radius    (cfg_q.radius),
		.desc      (desc_out),
		.desc_empty(desc_empty),
		.desc_pop  (desc_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	uvs_queue #(
		.T    (result_t),
		.Depth(QUEUE_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign item_kind = res_out.item_kind;
	assign pos_x     = $signed(res_out.pos_x);
	assign pos_y     = $signed(res_out.pos_y);
	assign pos_z     = $signed(res_out.pos_z);
	assign index_a   = res_out.index_a;
	assign index_b   = res_out.index_b;
	assign index_c   = res_out.index_c;
	assign last      = res_out.last;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import uvs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;

	typedef enum int {M_TOP, M_RING, M_BOT, M_TOP_FAN, M_QUAD, M_BOT_FAN} mesh_stage_t;

	class mesh_predictor;
		int sine_q15[SINE_TABLE_DEPTH];
		int unsigned radius_q88, rings_reg, slices_reg;
		mesh_stage_t stage;
		int unsigned ring_at, slice_at, second_half, slice_step, ring_step;
		result_t pending_items[$];
		int errors;

		function new();
			longint unsigned u, quad, r, y, y2, t, s, v;
			for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
				u = (longint'(k) << 32) / SINE_TABLE_DEPTH;
				quad = (u >> 30) & 3;
				r = u & (Q30_ONE - 1);
				if (quad[0])
					r = Q30_ONE - r;
				y = (r * HALF_PI_Q30) >> 30;
				y2 = (y * y) >> 30;
				t = Q30_ONE;
				t = Q30_ONE - ((y2 * t) >> 30) / 110;
				t = Q30_ONE - ((y2 * t) >> 30) / 72;
				t = Q30_ONE - ((y2 * t) >> 30) / 42;
				t = Q30_ONE - ((y2 * t) >> 30) / 20;
				t = Q30_ONE - ((y2 * t) >> 30) / 6;
				s = (y * t) >> 30;
				v = (s * 32767 + (64'd1 << 29)) >> 30;
				if (v > 32767)
					v = 32767;
				sine_q15[k] = quad[1] ? -int'(v) : int'(v);
			end
			radius_q88 = RADIUS_RST;
			rings_reg = RING_RST;
			slices_reg = SLICE_RST;
			stage = M_TOP;
			ring_at = 0;
			slice_at = 0;
			second_half = 0;
			slice_step = 0;
			ring_step = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_RADIUS: radius_q88 = data;
				REG_RING_COUNT: rings_reg = data[COUNT_W-1:0];
				REG_SLICE_COUNT: slices_reg = data[COUNT_W-1:0];
				default: ;
			endcase
		endfunction

		function longint sin_at(int unsigned ph);
			longint unsigned i;
			i = ((longint'(ph & 16'hFFFF) * SINE_TABLE_DEPTH + 32768) >> 16) % SINE_TABLE_DEPTH;
			return sine_q15[i];
		endfunction

		function longint round_off(longint p, int sh);
			longint m;
			m = (p < 0) ? -p : p;
			m = (m + (longint'(1) << (sh - 1))) >>> sh;
			return (p < 0) ? -m : m;
		endfunction

		function result_t vertex(longint x, longint y, longint z);
			result_t e;
			e = '0;
			e.pos_x = x[POS_W-1:0];
			e.pos_y = y[POS_W-1:0];
			e.pos_z = z[POS_W-1:0];
			return e;
		endfunction

		function result_t triangle(int unsigned a, int unsigned b, int unsigned c, bit fin);
			result_t e;
			e = '0;
			e.item_kind = 1'b1;
			e.index_a = a[IDX_W-1:0];
			e.index_b = b[IDX_W-1:0];
			e.index_c = c[IDX_W-1:0];
			e.last = fin;
			return e;
		endfunction

		function void note_request(bit rs);
			int unsigned nr, ns, c, k, th, ph, p0, p1, lo, pole;
			longint rsin;
			result_t e;
			nr = (rings_reg < 1) ? 1 : (rings_reg > MAX_RINGS) ? MAX_RINGS : rings_reg;
			ns = (slices_reg < 3) ? 3 : (slices_reg > MAX_SLICES) ? MAX_SLICES : slices_reg;
			if (rs) begin
				slice_step = (65536 + ns / 2) / ns;
				ring_step = (32768 + (nr + 1) / 2) / (nr + 1);
				stage = M_TOP;
				ring_at = 0;
				slice_at = 0;
				second_half = 0;
			end
			c = slice_at;
			k = ring_at;
			pole = nr * ns + 1;
			case (stage)
				M_RING: begin
					th = (k * ring_step) & 16'hFFFF;
					ph = (ns * slice_step - c * slice_step) & 16'hFFFF;
					rsin = longint'(radius_q88) * sin_at(th);
					e = vertex(round_off(rsin * sin_at(ph + QUARTER_TURN), 30),
						round_off(longint'(radius_q88) * sin_at(th + QUARTER_TURN), 15),
						round_off(rsin * sin_at(ph), 30));
					slice_at = c + 1;
					if (slice_at >= ns) begin
						slice_at = 0;
						ring_at = k + 1;
						if (ring_at > nr)
							stage = M_BOT;
					end
				end
				M_BOT: begin
					e = vertex(0, -longint'(radius_q88), 0);
					stage = M_TOP_FAN;
					slice_at = 0;
				end
				M_TOP_FAN: begin
					e = (c + 1 < ns) ? triangle(c + 2, c + 1, 0, 0) : triangle(1, ns, 0, 0);
					slice_at = c + 1;
					if (slice_at >= ns) begin
						slice_at = 0;
						ring_at = 1;
						second_half = 0;
						stage = (nr > 1) ? M_QUAD : M_BOT_FAN;
					end
				end
				M_QUAD: begin
					p0 = 1 + (k - 1) * ns;
					p1 = 1 + k * ns;
					if (c + 1 < ns)
						e = second_half ? triangle(p1 + c + 1, p1 + c, p0 + c + 1, 0)
							: triangle(p0 + c, p0 + c + 1, p1 + c, 0);
					else
						e = second_half ? triangle(p0 + ns, p1 + ns - 1, p0, 0)
							: triangle(p0, p1 + ns - 1, p0 + ns - 1, 0);
					if (!second_half) begin
						second_half = 1;
					end else begin
						second_half = 0;
						slice_at = c + 1;
						if (slice_at >= ns) begin
							slice_at = 0;
							ring_at = k + 1;
							if (ring_at >= nr)
								stage = M_BOT_FAN;
						end
					end
				end
				M_BOT_FAN: begin
					lo = 1 + (nr - 1) * ns;
					if (c + 1 < ns) begin
						e = triangle(lo + c, lo + c + 1, pole, 0);
						slice_at = c + 1;
					end else begin
						e = triangle(lo, pole, lo + ns - 1, 1);
						stage = M_TOP;
						slice_at = 0;
						ring_at = 0;
						second_half = 0;
					end
				end
				default: begin
					e = vertex(0, longint'(radius_q88), 0);
					stage = M_RING;
					ring_at = 1;
					slice_at = 0;
					second_half = 0;
				end
			endcase
			pending_items.push_back(e);
		endfunction

		function void check_item(result_t got);
			result_t e;
			if (pending_items.size() == 0) begin
				$error("unexpected item kind=%0d", got.item_kind);
				errors++;
				return;
			end
			e = pending_items.pop_front();
			if (got.item_kind !== e.item_kind) begin
				$error("item_kind: expected %0d, got %0d", e.item_kind, got.item_kind);
				errors++;
			end
			if (got.pos_x !== e.pos_x) begin
				$error("pos_x: expected %0h, got %0h", e.pos_x, got.pos_x);
				errors++;
			end
			if (got.pos_y !== e.pos_y) begin
				$error("pos_y: expected %0h, got %0h", e.pos_y, got.pos_y);
				errors++;
			end
			if (got.pos_z !== e.pos_z) begin
				$error("pos_z: expected %0h, got %0h", e.pos_z, got.pos_z);
				errors++;
			end
			if (got.index_a !== e.index_a) begin
				$error("index_a: expected %0d, got %0d", e.index_a, got.index_a);
				errors++;
			end
			if (got.index_b !== e.index_b) begin
				$error("index_b: expected %0d, got %0d", e.index_b, got.index_b);
				errors++;
			end
			if (got.index_c !== e.index_c) begin
				$error("index_c: expected %0d, got %0d", e.index_c, got.index_c);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;
	logic push = 1'b0;
	logic restart = 1'b0;
	logic pop = 1'b0;
	logic full, empty, item_kind, last;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic [IDX_W-1:0] index_a, index_b, index_c;

	mesh_predictor mesh = new();
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_left = 0;
	bit hold_go = 0;
	int quiet_cycles = 0;

	uv_sphere_mesh_generator_top u_dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// receiver side
	always @(negedge clk) begin
		if (hold_go) begin
			hold_left = HOLD_CYCLES;
			hold_go = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			mesh.check_item({item_kind, pos_x, pos_y, pos_z, index_a, index_b, index_c, last});
		if ((push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("uv_sphere_mesh_generator_top verification failed");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		mesh.set_reg(idx, data);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// called at a falling edge, returns at a falling edge with push still high
	task automatic send_request(bit rs);
		bit taken;
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		restart <= rs;
		taken = 0;
		while (!taken) begin
			@(posedge clk);
			if (!full) begin
				taken = 1;
				mesh.note_request(rs);
			end
			@(negedge clk);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (mesh.pending_items.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(int mode, int unsigned rad, int unsigned nr, int unsigned ns,
			int count, bit rs_first, bit squeeze, bit pause);
		int tx_tab[4] = '{0, 57, 0, 11};
		int rx_tab[4] = '{0, 0, 57, 11};
		write_reg(REG_RADIUS, CFG_W'(rad));
		write_reg(REG_RING_COUNT, CFG_W'(nr));
		write_reg(REG_SLICE_COUNT, CFG_W'(ns));
		tx_idle_pct = tx_tab[mode];
		rx_stall_pct = rx_tab[mode];
		if (squeeze)
			hold_go = 1;
		for (int i = 0; i < count; i++) begin
			if (pause && i == count / 2) begin
				push <= 1'b0;
				while (mesh.pending_items.size() > 0)
					@(negedge clk);
			end
			send_request((i == 0 && rs_first) || $urandom_range(49) == 0);
		end
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// before any restart the angle steps are zero
		for (int i = 0; i < 5; i++)
			send_request(0);
		send_request(1);
		for (int i = 0; i < 12; i++)
			send_request(0);
		send_request(1);
		send_request(0);
		drain();
		write_reg(REG_SPARE, 16'hFFFF);
		run_phase(0, 16'hFFFF, 1, 3, 60, 1, 0, 0);
		run_phase(1, 0, 0, 0, 30, 1, 0, 0);
		run_phase(2, $urandom_range(65535), 2, 4, 80, 1, 1, 0);
		run_phase(3, $urandom_range(65535), 64, 64, 40, 1, 0, 0);
		run_phase(0, $urandom_range(65535), 127, 127, 30, 1, 0, 0);
		run_phase(1, $urandom_range(65535), 3, 5, 100, 1, 0, 1);
		// counts change without a restart at the start of the phase
		run_phase(2, $urandom_range(65535), 5, 3, 100, 0, 0, 0);
		run_phase(3, $urandom_range(65535), 2, 6, 60, 0, 0, 0);
		if (mesh.errors == 0)
			$display("uv_sphere_mesh_generator_top verification clean");
		else
			$display("uv_sphere_mesh_generator_top verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/uvs_pkg.sv
rtl/uvs_queue.sv
rtl/uvs_front.sv
rtl/uvs_back.sv
rtl/uv_sphere_mesh_generator_top.sv
test/tb.sv
